>>> hdl/bale_pkg.sv
package bale_pkg;

    // Operation codes carried by each input transaction
    typedef enum logic [3:0] {
        OP_INS_AT    = 4'd0,
        OP_INS_END   = 4'd1,
        OP_INS_START = 4'd2,
        OP_DEL_AT    = 4'd3,
        OP_DEL_END   = 4'd4,
        OP_DEL_START = 4'd5,
        OP_SEARCH    = 4'd6,
        OP_READ      = 4'd7,
        OP_MAX       = 4'd8,
        OP_MIN       = 4'd9
    } op_t;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_BADPOS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // Field widths of the stream payloads
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // One result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status_code;
        logic [DATA_W-1:0]   result_data;
        logic [POS_W-1:0]    found_position;
        logic [FILL_W-1:0]   fill_count;
    } result_t;

endpackage

>>> hdl/bale_mem.sv
module bale_mem import bale_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bale_ctrl.sv
module bale_ctrl import bale_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4,
    parameter int CNT_W  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_func,
    input  logic [POS_W-1:0]  s_pos,
    input  logic [DATA_W-1:0] s_value,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    // Common width for comparing positions against the fill count
    localparam int PW = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic                up_reg, up_next;
    logic                rv_reg, rv_next;
    logic [ADDR_W-1:0]   raddr_d_reg, raddr_d_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [ADDR_W-1:0]   fpos_reg, fpos_next;

    logic [PW-1:0]       cnt_ext;
    logic [PW-1:0]       cnt_m1;
    logic [PW-1:0]       tgt;
    logic [CNT_W-1:0]    cnt_after;
    op_t                 op_in;
    logic                is_ins;
    logic                is_del;

    assign cnt_ext = PW'(cnt_reg);
    assign cnt_m1  = cnt_ext - PW'(1);
    assign op_in   = op_t'(s_func);
    assign is_ins  = (op_reg == OP_INS_AT) || (op_reg == OP_INS_END)
                  || (op_reg == OP_INS_START);
    assign is_del  = (op_reg == OP_DEL_AT) || (op_reg == OP_DEL_END)
                  || (op_reg == OP_DEL_START);

    // Count after the current operation commits
    always_comb
    begin
        cnt_after = cnt_reg;
        if (status_reg == ST_OK && is_ins)
        begin
            cnt_after = cnt_reg + CNT_W'(1);
        end
        else if (status_reg == ST_OK && is_del)
        begin
            cnt_after = cnt_reg - CNT_W'(1);
        end
    end

    assign res.status_code    = status_reg;
    assign res.result_data    = data_reg;
    assign res.found_position = POS_W'(fpos_reg);
    assign res.fill_count     = FILL_W'(cnt_after);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rv_reg    <= rv_next;
        end
    end

    // Operands, walk pointers and result accumulators
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        value_reg   <= value_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        up_reg      <= up_next;
        raddr_d_reg <= raddr_d_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
        fpos_reg    <= fpos_next;
    end

    // Sequencer: decode, walk the entries, process read data, deliver
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        value_next   = value_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        up_next      = up_reg;
        rv_next      = 1'b0;
        raddr_d_next = ptr_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        fpos_next    = fpos_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = ptr_reg;
        s_ready      = 1'b0;
        res_valid    = 1'b0;
        tgt          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    op_next     = op_in;
                    value_next  = s_value;
                    status_next = ST_OK;
                    data_next   = '0;
                    fpos_next   = '0;
                    state_next  = ST_FINISH;
                    unique case (op_in)
                        OP_INS_AT, OP_INS_END, OP_INS_START:
                        begin
                            if (op_in == OP_INS_AT)
                            begin
                                tgt = PW'(s_pos);
                            end
                            else if (op_in == OP_INS_END)
                            begin
                                tgt = cnt_ext;
                            end
                            if (cnt_ext == PW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (tgt > cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                pos_next = ADDR_W'(tgt);
                                // Shift entries up from the top, then place the value
                                if (tgt < cnt_ext)
                                begin
                                    ptr_next   = ADDR_W'(cnt_m1);
                                    end_next   = ADDR_W'(tgt);
                                    up_next    = 1'b0;
                                    state_next = ST_WALK;
                                end
                            end
                        end
                        OP_DEL_AT, OP_DEL_END, OP_DEL_START, OP_READ:
                        begin
                            if (op_in == OP_DEL_AT || op_in == OP_READ)
                            begin
                                tgt = PW'(s_pos);
                            end
                            else if (op_in == OP_DEL_END)
                            begin
                                tgt = cnt_m1;
                            end
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (tgt >= cnt_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                pos_next   = ADDR_W'(tgt);
                                ptr_next   = ADDR_W'(tgt);
                                end_next   = (op_in == OP_READ) ? ADDR_W'(tgt)
                                                                : ADDR_W'(cnt_m1);
                                up_next    = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        OP_SEARCH:
                        begin
                            status_next = ST_NOTFOUND;
                            if (cnt_reg != '0)
                            begin
                                ptr_next   = '0;
                                end_next   = ADDR_W'(cnt_m1);
                                up_next    = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        OP_MAX, OP_MIN:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                end_next   = ADDR_W'(cnt_m1);
                                up_next    = 1'b1;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            // Unused codes: report ok and leave the list alone
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Issue one read per cycle; the data arrives next cycle
                rv_next      = 1'b1;
                raddr_d_next = ptr_reg;
                if (ptr_reg == end_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ptr_next = up_reg ? ptr_reg + ADDR_W'(1) : ptr_reg - ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_valid = 1'b1;
                // Place the inserted value; repeating the write while stalled is harmless
                if (status_reg == ST_OK && is_ins)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_reg;
                    mem_wdata = value_reg;
                end
                if (res_ready)
                begin
                    cnt_next   = cnt_after;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Process read data. A shift writes each entry one place away from where it
        // was read, behind the walk, so reads and writes never touch the same entry.
        if (rv_reg)
        begin
            unique case (op_reg)
                OP_INS_AT, OP_INS_END, OP_INS_START:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = raddr_d_reg + ADDR_W'(1);
                    mem_wdata = mem_rdata;
                end
                OP_DEL_AT, OP_DEL_END, OP_DEL_START:
                begin
                    if (raddr_d_reg == pos_reg)
                    begin
                        data_next = mem_rdata;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = raddr_d_reg - ADDR_W'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                OP_SEARCH:
                begin
                    if (mem_rdata == value_reg && status_reg != ST_OK)
                    begin
                        status_next = ST_OK;
                        fpos_next   = raddr_d_reg;
                    end
                end
                OP_READ:
                begin
                    data_next = mem_rdata;
                end
                OP_MAX:
                begin
                    if (raddr_d_reg == '0 || $signed(data_reg) < $signed(mem_rdata))
                    begin
                        data_next = mem_rdata;
                    end
                end
                OP_MIN:
                begin
                    if (raddr_d_reg == '0 || $signed(mem_rdata) < $signed(data_reg))
                    begin
                        data_next = mem_rdata;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> hdl/bounded_array_list_engine.sv
// Channel  | Direction | tdata (low bit up)                        | tuser
// ---------+-----------+-------------------------------------------+----------------
// s_axis   | in        | position_in[3:0], item_value[35:4], 0 pad | func[3:0]
// m_axis   | out       | result_data[31:0], found_position[35:32], | status_code[2:0]
//          |           | fill_count[40:36], 0 pad                  |
//
// An operation that touches no entry goes from accept straight to the finish state.
// Shifts, search, max and min walk the entry memory one entry per cycle
// through its single read port: insert walks count-pos entries, delete
// count-pos, search/max/min count, read one; a drain state for the
// registered read and the finish state for delivery follow the walk.
// Reset clears the fill count and the sequencer; memory contents are not cleared.
// A finished result waits in the output register, so the next transaction
// is taken while m_axis is stalled.
module bounded_array_list_engine import bale_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position_in, item_value, pad
    input  logic [3:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // result_data, found_position, fill_count, pad
    output logic [2:0]  m_axis_tuser    // status_code
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    bale_ctrl #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_func    (s_axis_tuser),
        .s_pos     (s_axis_tdata[3:0]),
        .s_value   (s_axis_tdata[35:4]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bale_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: load a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status_code;
    assign m_axis_tdata  = {7'd0, out_reg.fill_count, out_reg.found_position,
                            out_reg.result_data};

endmodule

>>> hdl/bale_checker.sv
module bale_checker import bale_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result holds its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // A failed operation returns no data and no position
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[35:0] == 36'd0)
        else $error("failed operation carries data");

    // The fill count never exceeds the list depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (LIST_DEPTH > 31) || (m_axis_tdata[40:36] <= 5'(LIST_DEPTH)))
        else $error("fill count beyond list depth");

    // The engine takes one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an operation is in progress");

endmodule

bind bounded_array_list_engine bale_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_bale_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/bounded_array_list_engine_tb.sv
module bounded_array_list_engine_tb;
    import bale_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_CYCLES = 2 * (LIST_DEPTH + 3) + 8;
    localparam int TIMEOUT      = 2_000_000;
    localparam int PRINT_LIMIT  = 40;

    // Codes past the last operation; the block answers them with a plain ok
    localparam logic [3:0] OP_RESERVED_LO = 4'd10;
    localparam logic [3:0] OP_RESERVED_HI = 4'd15;

    // Operation mix of one random phase
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } mix_t;

    // One row of the directed table; fixed_want marks a result typed in here
    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  pos;
        logic [31:0] value;
        logic        fixed_want;
        result_t     want;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED_OPS [DIR_ROWS] = '{
        // every removal and lookup on an empty list
        '{OP_DEL_END,   4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_DEL_START, 4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_DEL_AT,    4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_READ,      4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_MAX,       4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_MIN,       4'd0,  32'd0,        1'b1, '{ST_EMPTY,    32'd0, 4'd0, 5'd0}},
        '{OP_SEARCH,    4'd0,  32'd0,        1'b1, '{ST_NOTFOUND, 32'd0, 4'd0, 5'd0}},
        // insert past the fill count, then an unused code
        '{OP_INS_AT,    4'd1,  32'd5,        1'b1, '{ST_BADPOS,   32'd0, 4'd0, 5'd0}},
        '{OP_RESERVED_HI, 4'd15, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'd0, 4'd0, 5'd0}},
        // build a list from the value extremes, then max, min and searches on it
        '{OP_INS_END,   4'd0,  32'h7FFF_FFFF, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd1}},
        '{OP_INS_START, 4'd0,  32'h8000_0000, 1'b1, '{ST_OK,      32'd0, 4'd0, 5'd2}},
        '{OP_INS_AT,    4'd2,  32'd0,        1'b1, '{ST_OK,       32'd0, 4'd0, 5'd3}},
        '{OP_INS_AT,    4'd1,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_MAX,       4'd0,  32'd0,        1'b0, '0},
        '{OP_MIN,       4'd0,  32'd0,        1'b0, '0},
        '{OP_SEARCH,    4'd0,  32'd0,        1'b0, '0},
        '{OP_SEARCH,    4'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SEARCH,    4'd0,  32'd12345,    1'b0, '0},
        // positions at and past the fill count, then valid reads, removals and an unused code
        '{OP_READ,      4'd15, 32'd0,        1'b1, '{ST_BADPOS,   32'd0, 4'd0, 5'd4}},
        '{OP_DEL_AT,    4'd4,  32'd0,        1'b1, '{ST_BADPOS,   32'd0, 4'd0, 5'd4}},
        '{OP_READ,      4'd2,  32'd0,        1'b0, '0},
        '{OP_DEL_AT,    4'd1,  32'd0,        1'b0, '0},
        '{OP_DEL_END,   4'd0,  32'd0,        1'b0, '0},
        '{OP_DEL_START, 4'd0,  32'd0,        1'b0, '0},
        '{OP_RESERVED_LO, 4'd15, 32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'd0, 4'd0, 5'd1}}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [3:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Shadow copy of the list, updated as each transaction is accepted
    logic [31:0] shadow_list [LIST_DEPTH];
    int          shadow_len = 0;

    result_t     pending_results [$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;

    bounded_array_list_engine #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, field, got, want);
    endtask

    // Open a slot at pos and shift later entries up
    function automatic logic [2:0] shadow_put(input int pos, input logic [31:0] value);
        if (shadow_len >= LIST_DEPTH)
            return ST_FULL;
        if (pos > shadow_len)
            return ST_BADPOS;
        for (int k = shadow_len; k > pos; k--)
            shadow_list[k] = shadow_list[k - 1];
        shadow_list[pos] = value;
        shadow_len++;
        return ST_OK;
    endfunction

    // Remove the entry at pos and close the gap
    function automatic logic [2:0] shadow_take(input int pos, output logic [31:0] removed);
        removed = '0;
        if (shadow_len == 0)
            return ST_EMPTY;
        if (pos >= shadow_len)
            return ST_BADPOS;
        removed = shadow_list[pos];
        for (int k = pos; k + 1 < shadow_len; k++)
            shadow_list[k] = shadow_list[k + 1];
        shadow_len--;
        return ST_OK;
    endfunction

    // Work out the result of one operation and apply it to the shadow list
    function automatic result_t predict_list_op(input logic [3:0] func, input logic [3:0] pos,
                                                input logic [31:0] value);
        result_t            res;
        logic [31:0]        removed;
        logic signed [31:0] best;
        bit                 hit;

        res = '0;
        res.status_code = ST_OK;
        removed = '0;
        case (func)
            OP_INS_AT:    res.status_code = shadow_put(int'(pos), value);
            OP_INS_END:   res.status_code = shadow_put(shadow_len, value);
            OP_INS_START: res.status_code = shadow_put(0, value);
            OP_DEL_AT:    res.status_code = shadow_take(int'(pos), removed);
            OP_DEL_END:
            begin
                if (shadow_len == 0)
                    res.status_code = ST_EMPTY;
                else
                    res.status_code = shadow_take(shadow_len - 1, removed);
            end
            OP_DEL_START: res.status_code = shadow_take(0, removed);
            OP_SEARCH:
            begin
                hit = 1'b0;
                res.status_code = ST_NOTFOUND;
                for (int k = 0; k < shadow_len; k++)
                begin
                    if (!hit && shadow_list[k] == value)
                    begin
                        hit = 1'b1;
                        res.status_code = ST_OK;
                        res.found_position = 4'(k);
                    end
                end
            end
            OP_READ:
            begin
                if (shadow_len == 0)
                    res.status_code = ST_EMPTY;
                else if (int'(pos) >= shadow_len)
                    res.status_code = ST_BADPOS;
                else
                    removed = shadow_list[pos];
            end
            OP_MAX, OP_MIN:
            begin
                if (shadow_len == 0)
                begin
                    res.status_code = ST_EMPTY;
                end
                else
                begin
                    best = shadow_list[0];
                    for (int k = 1; k < shadow_len; k++)
                    begin
                        if ((func == OP_MAX) ? ($signed(shadow_list[k]) > best)
                                             : ($signed(shadow_list[k]) < best))
                            best = shadow_list[k];
                    end
                    removed = best;
                end
            end
            default: ;
        endcase
        res.result_data = removed;
        res.fill_count = 5'(shadow_len);
        return res;
    endfunction

    // Present one transaction, wait for the accept and queue what it should return
    task automatic send_list_op(input logic [3:0] func, input logic [3:0] pos,
                                input logic [31:0] value, input logic fixed_want,
                                input result_t want);
        int      gap;
        result_t predicted;

        gap = draw_wait();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, value, pos};
        s_axis_tuser  <= func;
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        predicted = predict_list_op(func, pos, value);
        pending_results.push_back(fixed_want ? want : predicted);
        @(negedge clk);
    endtask

    function automatic logic [3:0] pick_op(input mix_t mix);
        int r;

        r = $urandom_range(0, 99);
        if (mix == MIX_GROW && r < 80)
            return 4'($urandom_range(OP_INS_AT, OP_INS_START));
        if (mix == MIX_SHRINK && r < 70)
            return 4'($urandom_range(OP_DEL_AT, OP_DEL_START));
        if (r >= 96)
            return 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
        return 4'($urandom_range(OP_INS_AT, OP_MIN));
    endfunction

    // Mostly positions inside the list or one past it, sometimes anywhere
    function automatic logic [3:0] pick_pos();
        if ($urandom_range(0, 3) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, (shadow_len < 15) ? shadow_len : 15));
    endfunction

    // Favor values already stored and a small pool so searches hit and ties occur
    function automatic logic [31:0] pick_value(input logic [3:0] func);
        if (func == OP_SEARCH && shadow_len > 0 && $urandom_range(0, 9) < 6)
            return shadow_list[$urandom_range(0, shadow_len - 1)];
        if ($urandom_range(0, 9) < 4)
        begin
            case ($urandom_range(0, 5))
                0:       return 32'd0;
                1:       return 32'd1;
                2:       return 32'hFFFF_FFFF;
                3:       return 32'h8000_0000;
                4:       return 32'h7FFF_FFFF;
                default: return 32'd42;
            endcase
        end
        return $urandom;
    endfunction

    // Result side: random stalls, compare each transaction with the oldest prediction
    initial
    begin : result_monitor
        int      gap;
        result_t want;

        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = draw_wait();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (m_axis_tvalid !== 1'b1)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", m_axis_tdata[31:0], '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status_code)
                    report_mismatch("status_code", 32'(m_axis_tuser), 32'(want.status_code));
                if (m_axis_tdata[31:0] !== want.result_data)
                    report_mismatch("result_data", m_axis_tdata[31:0], want.result_data);
                if (m_axis_tdata[35:32] !== want.found_position)
                    report_mismatch("found_position", 32'(m_axis_tdata[35:32]),
                                    32'(want.found_position));
                if (m_axis_tdata[40:36] !== want.fill_count)
                    report_mismatch("fill_count", 32'(m_axis_tdata[40:36]),
                                    32'(want.fill_count));
            end
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        logic [3:0] func;
        mix_t       mix;
        int         random_done;
        int         phase_len;
        int         phase;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_list_op(DIRECTED_OPS[i].func, DIRECTED_OPS[i].pos, DIRECTED_OPS[i].value,
                         DIRECTED_OPS[i].fixed_want, DIRECTED_OPS[i].want);

        random_done = 0;
        phase = 0;
        while (random_done < RANDOM_ITEMS)
        begin
            // hold the sender until the block has answered everything
            if (phase == 0 || $urandom_range(0, 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            mix = mix_t'($urandom_range(MIX_GROW, MIX_ANY));
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(30, 80);
            for (int j = 0; j < phase_len; j++)
            begin
                func = pick_op(mix);
                send_list_op(func, pick_pos(), pick_value(func), 1'b0, '0);
                if (func <= OP_MIN)
                    random_done++;
            end
            phase++;
        end

        // drain, then watch for stray results
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
